// ===== design/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants of the block linear resampler
// Register indexes, item classes, the control word carried from the front
// part to the back part, and fixed field widths.
// ----------------------------------------------------------------------------
package brs_pkg;

   // Fixed register and position widths
   localparam int STEP_W    = 18;
   localparam int LEN_W     = 10;
   localparam int CSR_DATA_W = 18;
   localparam int PHASE_W   = 25;
   localparam int FRAC_BITS = 16;
   localparam int INT_W     = PHASE_W - FRAC_BITS;

   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
   localparam int MIN_LEN    = 2;
   localparam int LEN_LIMIT  = (1 << LEN_W) - 1;

   localparam logic [STEP_W-1:0] STEP_RESET = 18'd52016;
   localparam logic [LEN_W-1:0]  LEN_RESET  = 10'd512;

   // Request queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_LVL_W = 3;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_STEP_RATIO   = 1'b0,
      CSR_BLOCK_LENGTH = 1'b1
   } csr_index_type;

   // Class of one request, set by the front part
   typedef enum logic [1:0] {
      OP_ZERO   = 2'd0,
      OP_SINGLE = 2'd1,
      OP_INTERP = 2'd2
   } op_type;

   // Control word that travels with the two stored samples
   typedef struct packed {
      op_type               op;
      logic [FRAC_BITS-1:0] frac;
      logic                 last;
   } ctl_type;

endpackage

// ===== design/brs_store.sv =====
// ----------------------------------------------------------------------------
// brs_store: double-buffered sample store
// One write port and two read ports; read data is registered.
// ----------------------------------------------------------------------------
module brs_store #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_a_addr,
   input  logic [ADDR_W-1:0] rd_b_addr,
   output logic [DATA_W-1:0] rd_a_data,
   output logic [DATA_W-1:0] rd_b_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read both neighbors every cycle
   always_ff @(posedge clock) begin
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ===== design/brs_front.sv =====
// ----------------------------------------------------------------------------
// brs_front: request intake and classification
// Holds the configuration and the block state, writes each request sample
// into the store, issues the neighbor reads of the previous block and passes
// a classified control word toward the queue.
// ----------------------------------------------------------------------------
module brs_front #(
   parameter int MAX_BLOCK   = 512,
   parameter int SAMPLE_BITS = 16,
   localparam int ADDR_W = $clog2(2 * MAX_BLOCK)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  brs_pkg::csr_index_type     csr_index,
   input  logic [brs_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [SAMPLE_BITS-1:0]     req_sample_in,
   input  logic [brs_pkg::Q_LVL_W-1:0] q_level,
   output logic                       wr_en,
   output logic [ADDR_W-1:0]          wr_addr,
   output logic [SAMPLE_BITS-1:0]     wr_data,
   output logic [ADDR_W-1:0]          rd_a_addr,
   output logic [ADDR_W-1:0]          rd_b_addr,
   output logic                       push,
   output brs_pkg::ctl_type           push_ctl
);

   import brs_pkg::*;

   localparam int IDX_W   = $clog2(MAX_BLOCK);
   localparam int CMP_W   = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;
   localparam int LEN_MAX = (MAX_BLOCK < LEN_LIMIT) ? MAX_BLOCK : LEN_LIMIT;
   localparam int TH_W    = CMP_W + FRAC_BITS;
   localparam int NEXT_W  = PHASE_W + 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(2 * MAX_BLOCK - 1);
   localparam logic [ADDR_W-1:0] HALF_BASE = ADDR_W'(MAX_BLOCK);

   logic [STEP_W-1:0]  step_ratio_ff;
   logic [LEN_W-1:0]   block_length_ff;
   logic               clearing_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [IDX_W-1:0]   wp_ff, wp_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               tail_ff, tail_in;
   logic               half_ff, half_in;
   logic               s1_valid_ff;
   ctl_type            s1_ctl_ff, s1_ctl_in;

   logic               accept;
   logic [CMP_W-1:0]   bl_ext, len_cmp, len_m1;
   logic               last;
   logic               single;
   logic [INT_W-1:0]   i1;
   logic [IDX_W-1:0]   ia, ib, wp_idx;
   logic [NEXT_W-1:0]  next_phase;
   logic [TH_W-1:0]    thresh;
   logic               reach;
   logic [Q_LVL_W-1:0] pending;

   // Hold off requests during the clearing pass and when the queue may fill
   assign pending   = q_level + Q_LVL_W'(s1_valid_ff);
   assign req_stall = clearing_ff || (pending >= Q_LVL_W'(Q_DEPTH));
   assign accept    = req_valid && !req_stall;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ratio_ff   <= STEP_RESET;
         block_length_ff <= LEN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_RATIO:   step_ratio_ff   <= csr_data[STEP_W-1:0];
            CSR_BLOCK_LENGTH: block_length_ff <= csr_data[LEN_W-1:0];
            default:          step_ratio_ff   <= step_ratio_ff;
         endcase
      end
   end

   // Clamp the block length into the supported range
   always_comb begin
      bl_ext = CMP_W'(block_length_ff);
      if (bl_ext < CMP_W'(MIN_LEN)) begin
         len_cmp = CMP_W'(MIN_LEN);
      end else if (bl_ext > CMP_W'(LEN_MAX)) begin
         len_cmp = CMP_W'(LEN_MAX);
      end else begin
         len_cmp = bl_ext;
      end
      len_m1 = len_cmp - CMP_W'(1);
   end

   // Classify the request and work out the next block state
   always_comb begin
      i1         = phase_ff[PHASE_W-1:FRAC_BITS];
      ia         = IDX_W'(i1);
      ib         = IDX_W'({1'b0, i1} + (INT_W + 1)'(1));
      wp_idx     = wp_ff;
      last       = (CMP_W'(wp_ff) + CMP_W'(1)) >= len_cmp;
      single     = (CMP_W'(i1) + CMP_W'(1)) >= len_cmp;
      next_phase = NEXT_W'(phase_ff) + NEXT_W'(step_ratio_ff);
      thresh     = {len_m1, {FRAC_BITS{1'b0}}};
      reach      = TH_W'(next_phase) >= thresh;

      s1_ctl_in.frac = phase_ff[FRAC_BITS-1:0];
      s1_ctl_in.last = last;
      priority if (tail_ff) begin
         s1_ctl_in.op = OP_ZERO;
      end else if (single) begin
         s1_ctl_in.op = OP_SINGLE;
      end else begin
         s1_ctl_in.op = OP_INTERP;
      end

      wp_in    = wp_ff;
      phase_in = phase_ff;
      tail_in  = tail_ff;
      half_in  = half_ff;
      if (accept) begin
         if (last) begin
            wp_in    = '0;
            phase_in = '0;
            tail_in  = 1'b0;
            half_in  = ~half_ff;
         end else begin
            wp_in = wp_ff + IDX_W'(1);
            if (!tail_ff) begin
               if (reach) begin
                  tail_in = 1'b1;
               end else begin
                  phase_in = next_phase[PHASE_W-1:0];
               end
            end
         end
      end
   end

   // Block state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         phase_ff <= '0;
         tail_ff  <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         phase_ff <= phase_in;
         tail_ff  <= tail_in;
         half_ff  <= half_in;
      end
   end

   // Sweep the store to zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Store write and neighbor read addresses
   always_comb begin
      wr_en = clearing_ff || accept;
      if (clearing_ff) begin
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_addr = half_ff ? HALF_BASE + ADDR_W'(wp_idx) : ADDR_W'(wp_idx);
         wr_data = req_sample_in;
      end
      rd_a_addr = half_ff ? ADDR_W'(ia) : HALF_BASE + ADDR_W'(ia);
      rd_b_addr = half_ff ? ADDR_W'(ib) : HALF_BASE + ADDR_W'(ib);
   end

   // Align the control word with the registered read data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   assign push     = s1_valid_ff;
   assign push_ctl = s1_ctl_ff;

`ifndef SYNTHESIS
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (q_level < Q_LVL_W'(Q_DEPTH)))
      else $error("front pushed into a full queue");

   a_block_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (wp_ff == '0 && phase_ff == '0 && !tail_ff))
      else $error("block state not restarted after last request");
`endif

endmodule

// ===== design/brs_queue.sv =====
// ----------------------------------------------------------------------------
// brs_queue: short request queue between front and back
// Carries the control word and the two stored samples of each request.
// ----------------------------------------------------------------------------
module brs_queue #(
   parameter int DATA_W = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  brs_pkg::ctl_type            push_ctl,
   input  logic [DATA_W-1:0]           push_data,
   input  logic                        pop,
   output brs_pkg::ctl_type            head_ctl,
   output logic [DATA_W-1:0]           head_data,
   output logic                        not_empty,
   output logic [brs_pkg::Q_LVL_W-1:0] level
);

   import brs_pkg::*;

   ctl_type            ctl_ff  [Q_DEPTH];
   logic [DATA_W-1:0]  data_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [Q_LVL_W-1:0] level_ff, level_in;

   // Store an entry
   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff]  <= push_ctl;
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and level
   always_comb begin
      level_in = level_ff;
      unique case ({push, pop})
         2'b10:   level_in = level_ff + Q_LVL_W'(1);
         2'b01:   level_in = level_ff - Q_LVL_W'(1);
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         level_ff <= level_in;
      end
   end

   assign head_ctl  = ctl_ff[rd_ptr_ff];
   assign head_data = data_ff[rd_ptr_ff];
   assign not_empty = (level_ff != '0);
   assign level     = level_ff;

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (level_ff != '0))
      else $error("queue popped while empty");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= Q_LVL_W'(Q_DEPTH))
      else $error("queue level beyond depth");
`endif

endmodule

// ===== design/brs_back.sv =====
// ----------------------------------------------------------------------------
// brs_back: interpolation and result output
// Multiplies the neighbor difference by the fraction, rounds, adds the lower
// sample and holds the result, zero for tail requests, in the output register.
// ----------------------------------------------------------------------------
module brs_back #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_not_empty,
   input  brs_pkg::ctl_type       head_ctl,
   input  logic [SAMPLE_BITS-1:0] head_a,
   input  logic [SAMPLE_BITS-1:0] head_b,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                   rsp_block_end
);

   import brs_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
   localparam int RES_W  = SAMPLE_BITS + 2;

   logic                          advance;
   logic                          m_valid_ff;
   logic                          m_zero_ff;
   logic                          m_last_ff;
   logic [SAMPLE_BITS-1:0]        m_a_ff;
   logic signed [PROD_W-1:0]      m_prod_ff;
   logic signed [SAMPLE_BITS:0]   diff;
   logic [FRAC_BITS-1:0]          frac_eff;
   logic                          zero_eff;
   logic signed [PROD_W-1:0]      prod;
   logic signed [PROD_W-1:0]      rnd;
   logic signed [PROD_W-1:0]      shifted;
   logic [RES_W-1:0]              res;
   logic                          rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]        rsp_sample_ff;
   logic                          rsp_end_ff;

   // Move both stages whenever the output register can take a value
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && q_not_empty;

   // Pick the fraction by request class and form the product
   always_comb begin
      unique case (head_ctl.op)
         OP_INTERP: begin
            frac_eff = head_ctl.frac;
            zero_eff = 1'b0;
         end
         OP_SINGLE: begin
            frac_eff = '0;
            zero_eff = 1'b0;
         end
         default: begin
            frac_eff = '0;
            zero_eff = 1'b1;
         end
      endcase
      diff = $signed({head_b[SAMPLE_BITS-1], head_b}) -
             $signed({head_a[SAMPLE_BITS-1], head_a});
      prod = diff * $signed({1'b0, frac_eff});
   end

   // Multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= q_not_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_zero_ff <= zero_eff;
         m_last_ff <= head_ctl.last;
         m_a_ff    <= head_a;
         m_prod_ff <= prod;
      end
   end

   // Round half up and add the lower sample
   always_comb begin
      rnd     = m_prod_ff + $signed(PROD_W'(ROUND_HALF));
      shifted = rnd >>> FRAC_BITS;
      res     = {{2{m_a_ff[SAMPLE_BITS-1]}}, m_a_ff} + shifted[RES_W-1:0];
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sample_ff <= m_zero_ff ? '0 : res[SAMPLE_BITS-1:0];
         rsp_end_ff    <= m_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_block_end  = rsp_end_ff;

`ifndef SYNTHESIS
   a_tail_is_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && m_valid_ff && m_zero_ff) |=> (rsp_sample_ff == '0))
      else $error("tail request produced a nonzero sample");
`endif

endmodule

// ===== design/block_linear_resampler.sv =====
// ----------------------------------------------------------------------------
// block_linear_resampler: block-wise linear interpolation resampler
// Top level: front part, sample store, request queue and back part.
// ----------------------------------------------------------------------------
// Each request sample is written into one half of a double-buffered store
// while one response is produced from the previous block: the read position
// starts at zero for every block, advances by step_ratio (unsigned, 16
// fraction bits) per response and the two stored neighbors are interpolated
// and rounded half up; at the block end the lower sample stands alone, and
// once the position reaches block_length - 1 the rest of the block is zero.
// The block sustains one request and one response per clock while req_stall
// and rsp_stall stay low; a response passes through the store read register,
// the queue, the multiplier and the output register, and the dual-read store
// port sets the one-per-cycle figure. After reset all 2 * MAX_BLOCK store
// entries (1024 at the default) are swept to zero while req_stall is held high;
// configuration writes are taken at any time and csr_ready is always high.
// ----------------------------------------------------------------------------
module block_linear_resampler #(
   parameter int MAX_BLOCK   = 512,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  brs_pkg::csr_index_type     csr_index,
   input  logic [brs_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [SAMPLE_BITS-1:0]     req_sample_in,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [SAMPLE_BITS-1:0]     rsp_sample_out,
   output logic                       rsp_block_end
);

   import brs_pkg::*;

   localparam int DEPTH  = 2 * MAX_BLOCK;
   localparam int ADDR_W = $clog2(DEPTH);

   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [SAMPLE_BITS-1:0] wr_data;
   logic [ADDR_W-1:0]      rd_a_addr, rd_b_addr;
   logic [SAMPLE_BITS-1:0] rd_a_data, rd_b_data;
   logic                   push;
   ctl_type                push_ctl;
   logic                   pop;
   ctl_type                head_ctl;
   logic [2*SAMPLE_BITS-1:0] head_data;
   logic                   q_not_empty;
   logic [Q_LVL_W-1:0]     q_level;

   // Configuration writes never wait
   assign csr_ready = 1'b1;

   brs_front #(
      .MAX_BLOCK   (MAX_BLOCK),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_in (req_sample_in),
      .q_level       (q_level),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_a_addr     (rd_a_addr),
      .rd_b_addr     (rd_b_addr),
      .push          (push),
      .push_ctl      (push_ctl)
   );

   brs_store #(
      .DEPTH  (DEPTH),
      .DATA_W (SAMPLE_BITS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   brs_queue #(
      .DATA_W (2 * SAMPLE_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_ctl  (push_ctl),
      .push_data ({rd_a_data, rd_b_data}),
      .pop       (pop),
      .head_ctl  (head_ctl),
      .head_data (head_data),
      .not_empty (q_not_empty),
      .level     (q_level)
   );

   brs_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .head_ctl       (head_ctl),
      .head_a         (head_data[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .head_b         (head_data[SAMPLE_BITS-1:0]),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_block_end  (rsp_block_end)
   );

endmodule
